// File: rtl/sliding_window_max_average_top_assert.svh
// ----------------------------------------------------------------------------
// Sliding window max average - assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_AVERAGE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MAX_AVERAGE_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SWMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swma assertion failed: lbl");

// Antecedent implies consequent in the next cycle.
`define SWMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swma assertion failed: lbl");

`endif

// File: rtl/swma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window max average - package
// Shared constants and types of the window, divider and top level.
// ----------------------------------------------------------------------------
package swma_pkg;

    localparam int WINDOW_MAX  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 11;
    localparam int SUM_BITS    = 26;
    localparam int AVG_BITS    = 32;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int DIVD_BITS   = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS   = $clog2(DIVD_BITS);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic signed [AVG_BITS-1:0]    t_avg;
    typedef logic        [CFG_BITS-1:0]    t_cfg;
    typedef logic        [CNT_BITS-1:0]    t_cnt;
    typedef logic        [ADDR_BITS-1:0]   t_addr;

    // Best window of a finished sequence, handed to the divider.
    typedef struct packed {
        logic have;
        t_sum best;
    } t_seq_result;

endpackage

// File: rtl/sliding_window_max_average_top.sv
`timescale 1ns / 1ps
// Path: a sample marked last passes window stages 1 and 2, then the divider
//   loads the best sum, divides and fixes the sign before the result is registered.
// Throughput: 1 sample per cycle within a sequence, set by the single write and
//   read port of the ring memory; the divider serves one sequence end at a time.
// Reset: synchronous, active low; the sequence state empties and window_len is 1.
// ----------------------------------------------------------------------------
// Sliding window max average - top level
// Tracks the largest full-window sum of a sample sequence and its Q16 average.
// ----------------------------------------------------------------------------
`include "sliding_window_max_average_top_assert.svh"

module sliding_window_max_average_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: window length
    input  logic                  i_cfg_we,
    input  swma_pkg::t_cfg        i_cfg_wdata,
    // sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  swma_pkg::t_sample     i_sample,
    input  logic                  i_last_item,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output swma_pkg::t_sum        o_max_window_sum,
    output swma_pkg::t_avg        o_max_average_q16,
    output logic                  o_window_found
);
    import swma_pkg::*;

    // Effective window length, already clamped to 1 .. WINDOW_MAX.
    t_cnt r_len;
    t_cnt n_len;

    // High from acceptance of a last sample until its result transaction.
    logic r_seq_busy;

    logic r_out_valid;
    t_sum r_out_sum;
    t_avg r_out_avg;
    logic r_out_found;

    logic        in_accept;
    logic        out_accept;
    logic        seq_start;
    t_seq_result seq_result;
    logic        div_done;
    t_sum        div_sum;
    t_avg        div_avg;
    logic        div_found;

    // Clamp a written length: zero acts as one, anything above the ring size
    // saturates to the ring size.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_len = CNT_BITS'(1);
        end else if (32'(i_cfg_wdata) > WINDOW_MAX) begin
            n_len = CNT_BITS'(WINDOW_MAX);
        end else begin
            n_len = CNT_BITS'(i_cfg_wdata);
        end
    end

    // Hold off new samples while a sequence end is summed and divided; the
    // next sequence starts once its result transaction has gone out.
    assign o_in_ready = !r_seq_busy;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = r_out_valid && i_out_ready;

    swma_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_len    (r_len),
        .i_accept (in_accept),
        .i_sample (i_sample),
        .i_last   (i_last_item),
        .o_start  (seq_start),
        .o_result (seq_result)
    );

    swma_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (seq_start),
        .i_result (seq_result),
        .i_len    (r_len),
        .o_done   (div_done),
        .o_sum    (div_sum),
        .o_avg    (div_avg),
        .o_found  (div_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= CNT_BITS'(1);
            r_seq_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= n_len;
            end
            // set on the last sample, clear when the result is taken
            if (in_accept && i_last_item) begin
                r_seq_busy <= 1'b1;
            end else if (out_accept) begin
                r_seq_busy <= 1'b0;
            end
            if (div_done) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load once per sequence, hold until the transaction.
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_out_sum   <= div_sum;
            r_out_avg   <= div_avg;
            r_out_found <= div_found;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_max_window_sum  = r_out_sum;
    assign o_max_average_q16 = r_out_avg;
    assign o_window_found    = r_out_found;

    `SWMA_ASSERT_IMP(a_done_in_seq, i_clk, i_rst_n, div_done, r_seq_busy && !r_out_valid)
    `SWMA_ASSERT_IMP(a_out_in_seq, i_clk, i_rst_n, r_out_valid, r_seq_busy)
    `SWMA_ASSERT_NXT(a_last_blocks, i_clk, i_rst_n, in_accept && i_last_item, !o_in_ready)

endmodule

// File: rtl/swma_ring_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window max average - ring memory
// Simple dual port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module swma_ring_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/swma_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window max average - window tracker
// Ring pointer and fill count, running sum over the ring, best full window.
// ----------------------------------------------------------------------------
module swma_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  swma_pkg::t_cnt        i_len,
    input  logic                  i_accept,
    input  swma_pkg::t_sample     i_sample,
    input  logic                  i_last,
    output logic                  o_start,
    output swma_pkg::t_seq_result o_result
);
    import swma_pkg::*;

    localparam int PW = CNT_BITS + 1;

    // sequence control
    t_addr r_ptr;
    t_cnt  r_fill;

    // stage 1: sample in flight, waiting for the oldest ring entry
    logic    r_p1_valid;
    t_sample r_p1_sample;
    logic    r_p1_last;
    logic    r_p1_sub;
    logic    r_p1_full;

    // stage 2: new running sum, compare with best
    logic r_p2_valid;
    t_sum r_p2_sum;
    logic r_p2_full;
    logic r_p2_last;

    t_sum r_rs;
    t_sum r_best;
    logic r_have;

    logic          sub0;
    logic          full0;
    t_cnt          fill_inc;
    logic [PW-1:0] ptr_ext;
    logic [PW-1:0] len_ext;
    logic [PW-1:0] old_idx;
    t_addr         rd_addr;
    t_addr         ptr_next;
    t_sample       ram_rdata;
    t_sum          rs_new;
    logic          take;
    t_sum          best_fin;
    logic          have_fin;

    always_comb begin
        sub0     = (r_fill >= i_len);
        fill_inc = r_fill + CNT_BITS'(1);
        full0    = sub0 || (fill_inc == i_len);
        ptr_ext  = PW'(r_ptr);
        len_ext  = PW'(i_len);
        if (ptr_ext >= len_ext) begin
            old_idx = ptr_ext - len_ext;
        end else begin
            old_idx = ptr_ext + PW'(WINDOW_MAX) - len_ext;
        end
        rd_addr = old_idx[ADDR_BITS-1:0];
        if (PW'(r_ptr) + PW'(1) >= PW'(WINDOW_MAX)) begin
            ptr_next = '0;
        end else begin
            ptr_next = r_ptr + ADDR_BITS'(1);
        end
    end

    swma_ring_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_accept),
        .i_waddr (r_ptr),
        .i_wdata (i_sample),
        .i_re    (i_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // drop the oldest sample once the window is full, add the new one
    always_comb begin
        rs_new = r_rs + t_sum'(r_p1_sample);
        if (r_p1_sub) begin
            rs_new = rs_new - t_sum'(ram_rdata);
        end
    end

    always_comb begin
        take     = r_p2_valid && r_p2_full && (!r_have || (r_p2_sum > r_best));
        best_fin = take ? r_p2_sum : r_best;
        have_fin = r_have || (r_p2_valid && r_p2_full);
    end

    assign o_start  = r_p2_valid && r_p2_last;
    assign o_result = '{have: have_fin, best: best_fin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_fill     <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_rs       <= '0;
            r_best     <= '0;
            r_have     <= 1'b0;
        end else begin
            r_p1_valid <= i_accept;
            r_p2_valid <= r_p1_valid;

            if (i_clear) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (i_accept) begin
                r_ptr  <= i_last ? '0 : ptr_next;
                r_fill <= i_last ? '0 : (sub0 ? i_len : fill_inc);
            end

            if (i_clear) begin
                r_rs <= '0;
            end else if (r_p1_valid) begin
                r_rs <= r_p1_last ? '0 : rs_new;
            end

            if (i_clear) begin
                r_best <= '0;
                r_have <= 1'b0;
            end else if (r_p2_valid) begin
                r_best <= r_p2_last ? '0 : best_fin;
                r_have <= r_p2_last ? 1'b0 : have_fin;
            end
        end
    end

    // payload of the stages
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p1_sample <= i_sample;
            r_p1_last   <= i_last;
            r_p1_sub    <= sub0;
            r_p1_full   <= full0;
        end
        if (r_p1_valid) begin
            r_p2_sum  <= rs_new;
            r_p2_full <= r_p1_full;
            r_p2_last <= r_p1_last;
        end
    end

endmodule

// File: rtl/swma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window max average - average divider
// Floored signed division of best sum times 2^16 by the window length,
// one quotient bit per cycle, then sign fix and saturation.
// ----------------------------------------------------------------------------
`include "sliding_window_max_average_top_assert.svh"

module swma_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  swma_pkg::t_seq_result i_result,
    input  swma_pkg::t_cnt        i_len,
    output logic                  o_done,
    output swma_pkg::t_sum        o_sum,
    output swma_pkg::t_avg        o_avg,
    output logic                  o_found
);
    import swma_pkg::*;

    localparam longint AvgHi = (longint'(1) <<< (AVG_BITS - 1)) - 1;
    localparam longint AvgLo = -(longint'(1) <<< (AVG_BITS - 1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX
    } t_state;

    t_state                r_state;
    logic [STEP_BITS-1:0]  r_step;
    logic [DIVD_BITS-1:0]  r_dvd;
    t_cnt                  r_rem;
    logic                  r_neg;
    t_sum                  r_sum;
    logic                  r_have;
    logic                  r_done;
    t_avg                  r_avg;

    logic [SUM_BITS-1:0]       mag;
    logic [CNT_BITS:0]         rem_sh;
    logic                      qbit;
    t_cnt                      rem_nx;
    logic signed [DIVD_BITS:0] q_s;
    t_avg                      avg_sat;

    always_comb begin
        mag    = i_result.best[SUM_BITS-1] ? SUM_BITS'(-i_result.best)
                                           : SUM_BITS'(i_result.best);
        rem_sh = {r_rem, r_dvd[DIVD_BITS-1]};
        qbit   = (rem_sh >= (CNT_BITS+1)'(i_len));
        rem_nx = qbit ? CNT_BITS'(rem_sh - (CNT_BITS+1)'(i_len)) : rem_sh[CNT_BITS-1:0];

        q_s = $signed({1'b0, r_dvd});
        if (r_neg) begin
            q_s = -q_s;
            if (r_rem != '0) begin
                q_s = q_s - (DIVD_BITS+1)'(1);
            end
        end
        if (!r_have) begin
            avg_sat = '0;
        end else if (longint'(q_s) > AvgHi) begin
            avg_sat = AVG_BITS'(AvgHi);
        end else if (longint'(q_s) < AvgLo) begin
            avg_sat = AVG_BITS'(AvgLo);
        end else begin
            avg_sat = AVG_BITS'(q_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                        r_dvd   <= {mag, FRAC_BITS'(0)};
                        r_rem   <= '0;
                        r_neg   <= i_result.best[SUM_BITS-1];
                        r_sum   <= i_result.have ? i_result.best : '0;
                        r_have  <= i_result.have;
                    end
                end
                S_DIV: begin
                    r_dvd  <= {r_dvd[DIVD_BITS-2:0], qbit};
                    r_rem  <= rem_nx;
                    r_step <= r_step + STEP_BITS'(1);
                    if (r_step == STEP_BITS'(DIVD_BITS - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_avg   <= avg_sat;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_sum   = r_sum;
    assign o_avg   = r_avg;
    assign o_found = r_have;

    `SWMA_ASSERT_IMP(a_step_range, i_clk, i_rst_n, r_state == S_DIV, r_step < STEP_BITS'(DIVD_BITS))
    `SWMA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE)
    `SWMA_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_done && !o_found, (o_avg == '0) && (o_sum == '0))
    `SWMA_ASSERT_NXT(a_fix_done, i_clk, i_rst_n, r_state == S_FIX, o_done)

endmodule

// File: tb/sv/tb_sliding_window_max_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window max average - testbench
// Streams directed and random sample sequences through the block under
// several window lengths and idling patterns. A scoreboard predicts the best
// window sum and its Q16 average per sequence and checks every result.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_average_top;

    import swma_pkg::*;

    // Cycles to let pass after the last expected result before a register
    // write or the end of the run; covers the summing and divider pipeline.
    localparam int DRAIN_CYCLES = 60;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        t_sum max_sum;
        t_avg avg_q16;
        logic found;
    } t_window_result;

    // ------------------------------------------------------------------------
    // Scoreboard: window predictor plus queue of pending sequence results
    // ------------------------------------------------------------------------
    class swma_scoreboard;
        bit signed [SAMPLE_BITS-1:0] sample_hist [WINDOW_MAX];
        longint         window_sum;
        longint         best_sum;
        int unsigned    fill;
        int unsigned    wr_ptr;
        bit             have_full;
        t_cfg           window_len;
        t_window_result expected_results[$];
        int             mismatches;
        int             results_checked;
        int             samples_noted;

        function new();
            window_len      = t_cfg'(1);
            mismatches      = 0;
            results_checked = 0;
            samples_noted   = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            window_sum = 0;
            best_sum   = 0;
            fill       = 0;
            wr_ptr     = 0;
            have_full  = 1'b0;
        endfunction

        function void write_window_len(t_cfg value);
            window_len = value;
            clear_sequence();
        endfunction

        function int unsigned eff_len();
            if (window_len == 0) begin
                return 1;
            end
            if (window_len > WINDOW_MAX) begin
                return WINDOW_MAX;
            end
            return window_len;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_sample(t_sample s, logic last);
            int unsigned    k;
            int unsigned    old_idx;
            longint         kk;
            longint         num;
            longint         quot;
            longint         sum_sat;
            t_window_result res;
            k = eff_len();
            samples_noted++;
            // Retire the oldest sample once the window is full.
            if (fill >= k) begin
                old_idx = (wr_ptr >= k) ? wr_ptr - k : wr_ptr + WINDOW_MAX - k;
                window_sum -= sample_hist[old_idx];
                fill = k - 1;
            end
            sample_hist[wr_ptr] = s;
            wr_ptr = (wr_ptr + 1 >= WINDOW_MAX) ? 0 : wr_ptr + 1;
            window_sum += s;
            fill++;
            if (fill >= k) begin
                if (!have_full || window_sum > best_sum) begin
                    best_sum = window_sum;
                end
                have_full = 1'b1;
            end
            if (!last) begin
                return;
            end
            res = '0;
            if (have_full) begin
                kk   = k;
                num  = best_sum * 65536;
                quot = num / kk;
                if ((num % kk) != 0 && num < 0) begin
                    quot -= 1;
                end
                sum_sat = best_sum;
                if (sum_sat > 33554431)  sum_sat = 33554431;
                if (sum_sat < -33554432) sum_sat = -33554432;
                if (quot > 64'sd2147483647)  quot = 64'sd2147483647;
                if (quot < -64'sd2147483648) quot = -64'sd2147483648;
                res.max_sum = t_sum'(sum_sat);
                res.avg_q16 = t_avg'(quot);
                res.found   = 1'b1;
            end
            expected_results.push_back(res);
            clear_sequence();
        endfunction

        function void check_result(t_sum got_sum, t_avg got_avg, logic got_found);
            t_window_result exp_res;
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] unexpected result: sum %0d avg %0d found %0b",
                             $realtime, got_sum, got_avg, got_found);
                end
                return;
            end
            exp_res = expected_results.pop_front();
            if (got_sum !== exp_res.max_sum || got_avg !== exp_res.avg_q16 ||
                got_found !== exp_res.found) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] result %0d mismatch: sum exp %0d got %0d",
                             $realtime, results_checked, exp_res.max_sum, got_sum);
                    $display("    avg exp %0d got %0d, found exp %0b got %0b",
                             exp_res.avg_q16, got_avg, exp_res.found, got_found);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports, all inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_cfg_we    = 1'b0;
    t_cfg    i_cfg_wdata = '0;
    logic    i_in_valid  = 1'b0;
    logic    o_in_ready;
    t_sample i_sample    = '0;
    logic    i_last_item = 1'b0;
    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    t_sum    o_max_window_sum;
    t_avg    o_max_average_q16;
    logic    o_window_found;

    swma_scoreboard sb = new();

    // Idling percentages of the sample sender and the result receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;
    int cfg_writes    = 0;

    sliding_window_max_average_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_last_item       (i_last_item),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_max_window_sum  (o_max_window_sum),
        .o_max_average_q16 (o_max_average_q16),
        .o_window_found    (o_window_found)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stall the result channel at random; zero percent keeps ready high.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: sample both channels at the edge, as the block sees them.
    // Check the outgoing transaction before noting the incoming one; a result
    // always belongs to a sample accepted before it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_max_window_sum, o_max_average_q16, o_window_found);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_sample(i_sample, i_last_item);
            end
        end
        // Watchdog: count cycles with no transaction on either channel.
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles, %0d results pending",
                         $realtime, STALL_LIMIT, sb.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample; idle first at random, then hold valid and payload
    // until the block takes the transaction.
    task automatic send_sample(input t_sample s, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        i_last_item <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, wait for every pending result, then let the pipeline drain.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the window length only with the block idle; the write also
    // empties any unfinished sequence.
    task automatic set_window_len(input t_cfg value);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_window_len(value);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    function automatic t_sample pick_sample(input bit extreme);
        if (!extreme) begin
            return t_sample'($urandom);
        end
        case ($urandom_range(4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    // Send len samples; mark the final one last when closed is set.
    task automatic send_sequence(input int len, input bit extreme, input bit closed);
        for (int i = 0; i < len; i++) begin
            send_sample(pick_sample(extreme), closed && (i == len - 1));
        end
    endtask

    // Send the same value len times, the final one marked last.
    task automatic send_constant(input t_sample s, input int len);
        for (int i = 0; i < len; i++) begin
            send_sample(s, i == len - 1);
        end
    endtask

    // Random sequences for about n_items samples under the current window:
    // mostly full-window sequences, some short ones, some of extreme values,
    // and now and then a sequence left open for the next register write.
    task automatic run_random_phase(input int n_items);
        int k;
        int sent;
        int roll;
        int len;
        k    = sb.eff_len();
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(9);
            if (roll < 6) begin
                len = $urandom_range(2 * k + 3, k);
                send_sequence(len, 1'b0, 1'b1);
            end else if (roll < 8) begin
                len = $urandom_range(k, 1);
                send_sequence(len, 1'b0, 1'b1);
            end else begin
                len = $urandom_range(2 * k + 3, 1);
                send_sequence(len, 1'b1, 1'b1);
            end
            sent += len;
        end
        if ($urandom_range(1) == 1) begin
            send_sequence($urandom_range(k + 1, 1), 1'b0, 1'b0);
        end
    endtask

    function automatic t_cfg pick_window_len();
        int small_lens [6] = '{2, 3, 5, 8, 13, 31};
        case ($urandom_range(7))
            0:       return t_cfg'(0);
            1:       return t_cfg'(1);
            default: return t_cfg'(small_lens[$urandom_range(5)]);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset from time zero, then release it for good.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles at 20 percent, receiver at 60 percent.
        send_idle_pct = 20;
        recv_idle_pct = 60;

        // Directed: window length at its reset value of one.
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd100, 1'b1);

        // Zero length behaves as one.
        set_window_len(t_cfg'(0));
        send_sample(16'shFFFF, 1'b1);

        set_window_len(t_cfg'(3));
        // Short sequence: no full window, zero result.
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd20, 1'b1);
        // Exactly one window of the most negative sample.
        send_constant(16'sh8000, 3);
        // Quotients that need flooring, positive and negative.
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd2, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd2, 1'b1);
        // Leave a sequence open; the register write must empty it.
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd8, 1'b0);
        set_window_len(t_cfg'(2));
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd4, 1'b1);

        // An oversized length saturates to the ring depth: a short sequence
        // holds no full window.
        set_window_len(t_cfg'(2047));
        send_constant(16'sh8000, 5);

        // Random part: three idling patterns, four window settings each.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < 4; phase++) begin
                set_window_len(pick_window_len());
                run_random_phase(55);
            end
        end

        // Wait for the last results, then let the pipeline settle.
        drain_block();

        $display("Covered %0d samples across %0d window length writes,",
                 sb.samples_noted, cfg_writes);
        $display("checked %0d results, %0d mismatches", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
